// ----- hw/rtl/escape_time_pixel_iterator_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the escape-time pixel iterator
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_TIME_PIXEL_ITERATOR_CORE_ASSERT_SVH
`define ESCAPE_TIME_PIXEL_ITERATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// check that is masked while reset is asserted
`define ETPI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("etpi assertion failed");
// check that also holds during reset
`define ETPI_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("etpi reset assertion failed");
`else
`define ETPI_ASSERT(lbl, clk, rst_n, prop)
`define ETPI_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- hw/rtl/etpi_pkg.sv -----
// ----------------------------------------------------------------------------
// etpi_pkg
// Shared types, constants and helpers of the escape-time pixel iterator.
// ----------------------------------------------------------------------------
`default_nettype none

package etpi_pkg;

    localparam int DEF_FRAC_BITS  = 28;
    localparam int DEF_COORD_BITS = 12;
    localparam int DEF_ITER_BITS  = 16;

    localparam int DATA_BITS    = 32;
    localparam int REG_IDX_BITS = 3;
    localparam int ADDR_BITS    = REG_IDX_BITS + 2;

    // register reset values, Q4.28 where fractional
    localparam int unsigned    RST_MAX_ITER    = 255;
    localparam logic [31:0]    RST_REAL_ORIGIN = 32'hE000_0000; // -2.0
    localparam logic [31:0]    RST_IMAG_ORIGIN = 32'hF000_0000; // -1.0
    localparam logic [31:0]    RST_REAL_STEP   = 32'd786432;
    localparam logic [31:0]    RST_IMAG_STEP   = 32'd524288;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_MAX_ITER    = 3'd0,
        REG_REAL_ORIGIN = 3'd1,
        REG_IMAG_ORIGIN = 3'd2,
        REG_REAL_STEP   = 3'd3,
        REG_IMAG_STEP   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] real_origin;
        logic signed [31:0] imag_origin;
        logic signed [31:0] real_step;
        logic signed [31:0] imag_step;
    } cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic coord_mul;  // register index * step products
        logic c_load;     // form c, clear z and count
        logic mul;        // register squares and cross product of z
        logic step;       // write new z, bump count
        logic load_out;   // copy count into the output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic escape;     // |z|^2 above four
        logic count_zero;
        logic limit_hit;  // count has reached max_iter
    } dp_sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/escape_time_pixel_iterator_core.sv -----
// ----------------------------------------------------------------------------
// escape_time_pixel_iterator_core: Mandelbrot escape count for one pixel
// Setup of c, then one multiply / update pair per step until the limit or an
// escape stops the pixel.
// One pixel at a time: next beat taken in the cycle after the count is loaded, and
// a count still waiting on the output holds the sequencer in its last state.
// Reset: registers to defaults, sequencer idle, output empty, no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "escape_time_pixel_iterator_core_assert.svh"

module escape_time_pixel_iterator_core
    import etpi_pkg::*;
#(
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int ITER_BITS  = DEF_ITER_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_BITS-1:0]  paddr,
    input  wire logic [DATA_BITS-1:0]  pwdata,
    output logic      [DATA_BITS-1:0]  prdata,
    output logic                       pready,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [COORD_BITS-1:0] column,
    input  wire logic [COORD_BITS-1:0] row,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [ITER_BITS:0]    escape_count
);

    cfg_t                 cfg;
    logic [ITER_BITS-1:0] max_iter;
    dp_cmd_t              cmd;
    dp_sts_t              sts;

    etpi_regs #(
        .ITER_BITS (ITER_BITS)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .max_iter (max_iter)
    );

    etpi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    etpi_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS),
        .ITER_BITS  (ITER_BITS)
    ) u_dp (
        .clk          (clk),
        .cfg          (cfg),
        .max_iter     (max_iter),
        .column       (column),
        .row          (row),
        .cmd          (cmd),
        .sts          (sts),
        .escape_count (escape_count)
    );

    // one pixel in flight: an accepted beat closes the input side
    `ETPI_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready)
    // every finished pixel took at least one step
    `ETPI_ASSERT(a_count_nonzero, clk, rst_n, out_valid |-> escape_count != '0)
    // a reset edge leaves the output empty
    `ETPI_ASSERT_ALWAYS(a_no_result_in_reset, clk, !rst_n |=> !out_valid)

endmodule

`default_nettype wire

// ----- hw/rtl/etpi_regs.sv -----
// ----------------------------------------------------------------------------
// etpi_regs
// APB register file: iteration limit, origin and step of the complex plane.
// ----------------------------------------------------------------------------
`default_nettype none

module etpi_regs
    import etpi_pkg::*;
#(
    parameter int ITER_BITS = DEF_ITER_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic      [DATA_BITS-1:0] prdata,
    output logic                      pready,
    output cfg_t                      cfg,
    output logic      [ITER_BITS-1:0] max_iter
);

    logic [ITER_BITS-1:0] max_iter_reg;
    cfg_t                 cfg_reg;
    logic                 wr_en;
    reg_idx_t             idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg        <= ITER_BITS'(RST_MAX_ITER);
            cfg_reg.real_origin <= RST_REAL_ORIGIN;
            cfg_reg.imag_origin <= RST_IMAG_ORIGIN;
            cfg_reg.real_step   <= RST_REAL_STEP;
            cfg_reg.imag_step   <= RST_IMAG_STEP;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_MAX_ITER:    max_iter_reg        <= pwdata[ITER_BITS-1:0];
                REG_REAL_ORIGIN: cfg_reg.real_origin <= pwdata;
                REG_IMAG_ORIGIN: cfg_reg.imag_origin <= pwdata;
                REG_REAL_STEP:   cfg_reg.real_step   <= pwdata;
                REG_IMAG_STEP:   cfg_reg.imag_step   <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MAX_ITER:    prdata = DATA_BITS'(max_iter_reg);
            REG_REAL_ORIGIN: prdata = cfg_reg.real_origin;
            REG_IMAG_ORIGIN: prdata = cfg_reg.imag_origin;
            REG_REAL_STEP:   prdata = cfg_reg.real_step;
            REG_IMAG_STEP:   prdata = cfg_reg.imag_step;
            default:         prdata = '0;
        endcase
    end

    assign cfg      = cfg_reg;
    assign max_iter = max_iter_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/etpi_ctrl.sv -----
// ----------------------------------------------------------------------------
// etpi_ctrl
// Sequencer: setup of c, multiply / update loop, hand-off to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module etpi_ctrl
    import etpi_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output dp_cmd_t      cmd,
    input  wire dp_sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CADD,
        S_MUL,
        S_UPD,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   escaped;

    assign out_free = !out_valid_reg || out_ready;
    // first update sees the products of z = 0, no escape test there
    assign escaped  = !sts.count_zero && sts.escape;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.coord_mul = 1'b1;
                    state_next    = S_CADD;
                end
            end
            S_CADD:
            begin
                cmd.c_load = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (escaped)
                    state_next = S_FIN;
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = sts.limit_hit ? S_FIN : S_MUL;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/etpi_dp.sv -----
// ----------------------------------------------------------------------------
// etpi_dp
// Fixed-point datapath: c from pixel index, z = z*z + c, escape test.
// ----------------------------------------------------------------------------
`default_nettype none

module etpi_dp
    import etpi_pkg::*;
#(
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int ITER_BITS  = DEF_ITER_BITS
) (
    input  wire logic                  clk,
    input  wire cfg_t                  cfg,
    input  wire logic [ITER_BITS-1:0]  max_iter,
    input  wire logic [COORD_BITS-1:0] column,
    input  wire logic [COORD_BITS-1:0] row,
    input  wire dp_cmd_t               cmd,
    output dp_sts_t                    sts,
    output logic      [ITER_BITS:0]    escape_count
);

    localparam int          PROD_BITS  = COORD_BITS + 33;
    localparam logic [63:0] ESC_LIMIT  = 64'd4 << (2 * FRAC_BITS);

    logic signed [PROD_BITS-1:0] cprod_re_reg, cprod_im_reg;
    logic signed [31:0]          c_re_reg, c_im_reg;
    logic signed [31:0]          z_re_reg, z_im_reg;
    logic signed [63:0]          rr_reg, ii_reg, ri_reg;
    logic        [ITER_BITS:0]   count_reg;
    logic        [ITER_BITS:0]   escape_count_reg;

    logic signed [63:0] c_re_sum, c_im_sum;
    logic signed [63:0] diff;
    logic signed [63:0] re_sum, im_sum;
    logic        [63:0] mag_sum;

    assign c_re_sum = cprod_re_reg + cfg.real_origin;
    assign c_im_sum = cprod_im_reg + cfg.imag_origin;

    // floor shifts: arithmetic right shift of the exact products
    assign diff    = rr_reg - ii_reg;
    assign re_sum  = (diff >>> FRAC_BITS) + c_re_reg;
    assign im_sum  = (ri_reg >>> (FRAC_BITS - 1)) + c_im_reg;
    // squares are non-negative, so the sum fits unsigned
    assign mag_sum = $unsigned(rr_reg) + $unsigned(ii_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.coord_mul)
        begin
            cprod_re_reg <= $signed({1'b0, column}) * cfg.real_step;
            cprod_im_reg <= $signed({1'b0, row}) * cfg.imag_step;
        end
        if (cmd.c_load)
        begin
            c_re_reg  <= sat32(c_re_sum);
            c_im_reg  <= sat32(c_im_sum);
            z_re_reg  <= '0;
            z_im_reg  <= '0;
            count_reg <= '0;
        end
        if (cmd.mul)
        begin
            rr_reg <= z_re_reg * z_re_reg;
            ii_reg <= z_im_reg * z_im_reg;
            ri_reg <= z_re_reg * z_im_reg;
        end
        if (cmd.step)
        begin
            z_re_reg  <= sat32(re_sum);
            z_im_reg  <= sat32(im_sum);
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.load_out)
            escape_count_reg <= count_reg;
    end

    assign sts.escape     = (mag_sum > ESC_LIMIT);
    assign sts.count_zero = (count_reg == '0);
    assign sts.limit_hit  = (count_reg >= {1'b0, max_iter});

    assign escape_count = escape_count_reg;

endmodule

`default_nettype wire

// ----- bench/escape_time_pixel_iterator_core_tb.sv -----
// ----------------------------------------------------------------------------
// escape_time_pixel_iterator_core_tb: self-checking bench for the pixel core
// Pixels go in over a valid/ready channel, escape counts come back on another.
// Each count is predicted from the column, row and the current view registers
// and checked in order. Directed pixels cover the corners, the zero and full
// iteration limits, saturation of c, the escape boundary, over-wide register
// data and writes to unused addresses. Random views follow, mostly with random gaps
// on both channels.
// ----------------------------------------------------------------------------
module escape_time_pixel_iterator_core_tb
    import etpi_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC  = DEF_FRAC_BITS;
    localparam int COORD = DEF_COORD_BITS;
    localparam int ITERW = DEF_ITER_BITS;
    localparam longint unsigned ESCAPE_BOUND = 64'd4 << (2 * FRAC);
    localparam int LAST_REG_SLOT = 7;
    localparam int RANDOM_PHASES = 6;
    localparam int PIXELS_PER_PHASE = 72;

    typedef struct packed {
        logic [COORD-1:0] column;
        logic [COORD-1:0] row;
    } pixel_t;

    typedef struct {
        pixel_t         px;
        logic [ITERW:0] count;
    } escape_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr   = '0;
    logic [DATA_BITS-1:0] pwdata  = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic [COORD-1:0] column    = '0;
    logic [COORD-1:0] row       = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [ITERW:0]   escape_count;

    // view registers as the block should hold them
    logic [ITERW-1:0]   view_limit   = ITERW'(RST_MAX_ITER);
    logic signed [31:0] view_re_org  = RST_REAL_ORIGIN;
    logic signed [31:0] view_im_org  = RST_IMAG_ORIGIN;
    logic signed [31:0] view_re_step = RST_REAL_STEP;
    logic signed [31:0] view_im_step = RST_IMAG_STEP;

    pixel_t  pending_pixels[$];
    escape_t expected_counts[$];

    bit lazy_ports = 1'b0;
    int feed_gap   = 0;
    int drain_gap  = 0;
    int errors     = 0;
    int pixels_accepted = 0;
    int counts_checked  = 0;
    int limit_hits      = 0;
    int views_loaded    = 0;

    escape_time_pixel_iterator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .column       (column),
        .row          (row),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .escape_count (escape_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint clamp32(input longint v);
        longint r;
        if (v > 64'sd2147483647)
            r = 64'sd2147483647;
        else if (v < -64'sd2147483648)
            r = -64'sd2147483648;
        else
            r = v;
        return r;
    endfunction

    // z <- z*z + c from z = 0, counting steps until |z|^2 > 4 or past the limit
    function automatic logic [ITERW:0] escape_count_of(input pixel_t px);
        longint cr;
        longint ci;
        longint zr;
        longint zi;
        longint nr;
        longint ni;
        longint unsigned mag;
        int unsigned steps;
        cr = clamp32(longint'(view_re_org) + longint'(px.column) * longint'(view_re_step));
        ci = clamp32(longint'(view_im_org) + longint'(px.row) * longint'(view_im_step));
        zr = 0;
        zi = 0;
        steps = 0;
        forever
        begin
            nr = clamp32(((zr * zr - zi * zi) >>> FRAC) + cr);
            ni = clamp32(((zr * zi) >>> (FRAC - 1)) + ci);
            zr = nr;
            zi = ni;
            steps++;
            if (steps > view_limit)
                break;
            mag = longint'(zr * zr) + longint'(zi * zi);
            if (mag > ESCAPE_BOUND)
                break;
        end
        return steps[ITERW:0];
    endfunction

    // mostly back-to-back, sometimes a short gap, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // pixel driver: a beat holds until accepted, then an optional gap
    always @(posedge clk or negedge rst_n)
    begin : pixel_feed
        pixel_t px;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            feed_gap = 0;
        end
        else if (!(in_valid && !in_ready))
        begin
            if (in_valid)
            begin
                px.column = column;
                px.row    = row;
                expected_counts.push_back('{px, escape_count_of(px)});
                pixels_accepted++;
            end
            if (feed_gap > 0)
            begin
                feed_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_pixels.size() > 0)
            begin
                px = pending_pixels.pop_front();
                column   <= px.column;
                row      <= px.row;
                in_valid <= 1'b1;
                if (lazy_ports)
                    feed_gap = pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // count checker with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin : count_check
        escape_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            drain_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_counts.size() == 0)
                begin
                    $display("%0t: escape_count %0d with no pixel outstanding",
                             $time, escape_count);
                    errors++;
                end
                else
                begin
                    want = expected_counts.pop_front();
                    counts_checked++;
                    if (want.count == {1'b0, view_limit} + 1'b1)
                        limit_hits++;
                    if (escape_count !== want.count)
                    begin
                        $display("%0t: escape_count for (%0d,%0d): expected %0d, actual %0d",
                                 $time, want.px.column, want.px.row, want.count,
                                 escape_count);
                        errors++;
                    end
                end
                if (lazy_ports)
                    drain_gap = pick_gap();
            end
            if (drain_gap > 0)
            begin
                drain_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("escape_time_pixel_iterator_core_tb: done, errors");
        $finish;
    end

    // setup then access cycle; ends on a falling edge so queue updates stay clear
    task automatic write_reg(input int idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MAX_ITER:    view_limit   = value[ITERW-1:0];
            REG_REAL_ORIGIN: view_re_org  = value;
            REG_IMAG_ORIGIN: view_im_org  = value;
            REG_REAL_STEP:   view_re_step = value;
            REG_IMAG_STEP:   view_im_step = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_view(input logic [31:0] lim, input logic [31:0] re_org,
                            input logic [31:0] im_org, input logic [31:0] re_step,
                            input logic [31:0] im_step);
        write_reg(REG_MAX_ITER, lim);
        write_reg(REG_REAL_ORIGIN, re_org);
        write_reg(REG_IMAG_ORIGIN, im_org);
        write_reg(REG_REAL_STEP, re_step);
        write_reg(REG_IMAG_STEP, im_step);
        views_loaded++;
    endtask

    task automatic add_pixel(input int col, input int rw);
        pending_pixels.push_back('{COORD'(col), COORD'(rw)});
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0 || in_valid || expected_counts.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int lim;
        int re_org;
        int im_org;
        int re_step;
        int im_step;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset view: corners, checkerboard bits and c close to 0 (runs to the limit)
        add_pixel(0, 0);
        add_pixel(4095, 4095);
        add_pixel(0, 4095);
        add_pixel(4095, 0);
        add_pixel(12'hAAA, 12'h555);
        add_pixel(12'h555, 12'hAAA);
        add_pixel(683, 512);
        wait_drained();

        lazy_ports = 1'b1;
        // zero limit: every pixel stops after one step
        set_view(0, 0, 0, 0, 0);
        add_pixel(0, 0);
        add_pixel(4095, 4095);
        wait_drained();

        // c clamps high; limit written with junk above its width
        set_view(32'hFFFF_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_pixel(4095, 4095);
        add_pixel(0, 0);
        add_pixel(1, 4095);
        wait_drained();

        // c clamps low
        set_view(20, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_pixel(4095, 4095);
        add_pixel(7, 0);
        wait_drained();

        // c = -2 sits on |z|^2 == 4 every step; unused slots must not disturb it
        set_view(3, 32'hE000_0000, 0, 0, 0);
        for (int i = REG_IMAG_STEP + 1; i <= LAST_REG_SLOT; i++)
            write_reg(i, 32'hFFFF_FFFF);
        add_pixel(0, 0);
        add_pixel(4095, 4095);
        wait_drained();

        // full limit with c = 0: count carries into the top bit
        set_view(65535, 0, 0, 0, 0);
        add_pixel(4095, 4095);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: lim = $urandom_range(1, 16);
                1: lim = $urandom_range(17, 64);
                2: lim = 255;
                3: lim = $urandom_range(100, 400);
                4: lim = $urandom_range(1, 8);
                default: lim = $urandom_range(500, 1000);
            endcase
            if (p == RANDOM_PHASES - 1)
            begin
                // arbitrary register words: mostly fast escapes
                re_org  = $urandom;
                im_org  = $urandom;
                re_step = $urandom;
                im_step = $urandom;
            end
            else
            begin
                re_org  = int'($urandom_range(0, 32'h2800_0000)) - 32'h2000_0000;
                im_org  = int'($urandom_range(0, 32'h2800_0000)) - 32'h1400_0000;
                re_step = $urandom_range(1, 32'h3_0000);
                im_step = $urandom_range(1, 32'h3_0000);
                if ($urandom_range(0, 1))
                    re_step = -re_step;
                if ($urandom_range(0, 1))
                    im_step = -im_step;
            end
            set_view(lim, re_org, im_org, re_step, im_step);
            lazy_ports = (p != 1);
            for (int i = 0; i < PIXELS_PER_PHASE; i++)
            begin
                add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
                // hold the feed until every count is back, then resume
                if (p == 2 && i == PIXELS_PER_PHASE / 2)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (600) @(posedge clk);
        if (expected_counts.size() != 0)
        begin
            $display("%0t: %0d escape counts never arrived", $time, expected_counts.size());
            errors++;
        end
        $display("pixels: %0d accepted, %0d counts checked, %0d ran to the limit",
                 pixels_accepted, counts_checked, limit_hits);
        $display("views: %0d register settings, limits from 0 to 65535", views_loaded);
        if (errors == 0)
            $display("escape_time_pixel_iterator_core_tb: done, clean");
        else
            $display("escape_time_pixel_iterator_core_tb: done, errors");
        $finish;
    end

endmodule
